// ----- sv/pcc_pkg.sv -----
// Package for the pixel color correction unit: register indexes and reset values, luma
// weights, saturation unity and the exp2 factor table used by the power pipeline.
// No dependencies.
package pcc_pkg;

    // Fraction bits of the log2 value and length of the exp2 factor table
    localparam int LOG_BITS = 20;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PEDESTAL    = 2'd0,
        REG_INV_RANGE   = 2'd1,
        REG_GAMMA       = 2'd2,
        REG_SATURATION  = 2'd3
    } reg_idx_t;

    // Register reset values
    localparam logic [17:0] PEDESTAL_RST    = 18'd0;
    localparam logic [23:0] INV_RANGE_RST   = 24'd65536;
    localparam logic [15:0] GAMMA_RST       = 16'd4096;
    localparam logic [15:0] SATURATION_RST  = 16'd4096;

    // Luma weights in Q0.16, blue, green, red
    typedef logic [15:0] luma_w_t [0:2];
    localparam luma_w_t LUMA_W = '{16'd7471, 16'd38470, 16'd19595};

    // Saturation unity in Q4.12
    localparam logic signed [16:0] SAT_ONE = 17'sd4096;

    typedef logic [30:0] exp_tab_t [0:LOG_BITS-1];

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q1.30 factors 2^(2^-(i+1)), each the square root of the one before
    function automatic exp_tab_t exp_table();
        exp_tab_t   tab;
        logic [63:0] t;
        t = isqrt64(64'd1 << 61);
        tab[0] = t[30:0];
        for (int i = 1; i < LOG_BITS; i++) begin
            t = isqrt64(t << 30);
            tab[i] = t[30:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_table();

endpackage

// ----- sv/pixel_color_correction_unit.sv -----
// Pixel color correction: levels, gamma power, saturation mix, normalize.
// Depends on pcc_pkg (register indexes, luma weights, exp2 factor table).
//
//  channel   ports                         contents
//  input     s_tvalid s_tready s_tdata     blue, green, red bytes; tlast = block end
//            s_tlast
//  output    m_tvalid m_tready m_tdata     blue, green, red, alpha bytes; tlast copied
//            m_tlast
//  config    cfg_wr_en cfg_addr cfg_wdata  pedestal, inv_range, gamma, saturation
//
// One item per cycle sustained while the output is not stalled; most of the pipeline
// stages of each item lie in the 20-step log2 squaring chain and the 20-step exp2 product
// chain of each channel, then 8 steps of the byte divider.
// Reset (synchronous, active low) clears the valid bits and loads the configuration registers.
// All stages advance together whenever the output stage is empty or taken;
// a stall holds every stage in place.
module pixel_color_correction_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // blue_in [7:0], green_in [15:8], red_in [23:16]
    input  logic        s_tlast,    // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // blue_out, green_out, red_out, alpha_out from bit 0
    output logic        m_tlast,    // last_out
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    localparam int F    = FRAC_BITS;
    localparam int LB   = pcc_pkg::LOG_BITS;
    localparam int NW   = F + 1;
    localparam int BLW  = F + 2;
    localparam int DW   = F + 3;
    localparam int CW   = F + 11;
    localparam int CMW  = F + 10;
    localparam int PW   = $clog2(CMW);
    localparam int LIW  = $clog2(F + 1) + 1;
    localparam int LGW  = LIW + LB;
    localparam int YW   = LGW + 5;
    localparam int KW   = YW - LB;
    localparam int SW   = KW + 1;
    localparam int PWW  = F + 16;
    localparam int VW   = PWW + 7;
    localparam int MXW  = F + 3;
    localparam int NUMW = F + 11;
    localparam int NST  = 61;

    // Reciprocal of 255 for the byte-to-fraction scaling
    localparam int RK = 41;
    localparam logic [33:0] RECIP_255 = 34'(((64'd1 << RK) + 64'd254) / 64'd255);

    localparam logic [PWW-1:0]        ONE_P    = PWW'(1) << F;
    localparam logic [PWW-1:0]        POW_CAP  = PWW'(1) << (F + 15);
    localparam logic signed [KW-1:0]  K_CAP    = KW'(15);
    localparam logic signed [VW-1:0]  FOUR_V   = VW'(4) << F;
    localparam logic [MXW-1:0]        MX_FLOOR = MXW'((64'd1 << F) / 64'd10);

    // Configuration registers
    logic [17:0] pedestal_reg;
    logic [23:0] inv_range_reg;
    logic [15:0] gamma_reg;
    logic [15:0] saturation_reg;

    // Pipeline control
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST-1:0] lst_reg, lst_next;
    logic           adv;

    // Payload registers, per channel
    logic [NW-1:0]         n_reg     [0:2];
    logic [NW-1:0]         n_next    [0:2];
    logic [CW-1:0]         c_reg     [0:2];
    logic [CW-1:0]         c_next    [0:2];
    logic [CMW-1:0]        raw_reg   [0:2];
    logic [CMW-1:0]        raw_next  [0:2];
    logic [PW-1:0]         p_reg     [0:2];
    logic [PW-1:0]         p_next    [0:2];
    logic                  cp0_reg   [0:2];
    logic                  cp0_next  [0:2];
    logic [30:0]           lm_reg    [0:LB][0:2];
    logic [30:0]           lm_next   [0:LB][0:2];
    logic [LB-1:0]         lf_reg    [0:LB][0:2];
    logic [LB-1:0]         lf_next   [0:LB][0:2];
    logic [LIW-1:0]        lgi_reg   [0:LB][0:2];
    logic [LIW-1:0]        lgi_next  [0:LB][0:2];
    logic                  cpl_reg   [0:LB][0:2];
    logic                  cpl_next  [0:LB][0:2];
    logic [YW-1:0]         y_reg     [0:2];
    logic [YW-1:0]         y_next    [0:2];
    logic                  cpy_reg   [0:2];
    logic                  cpy_next  [0:2];
    logic [30:0]           er_reg    [0:LB][0:2];
    logic [30:0]           er_next   [0:LB][0:2];
    logic [LB-1:0]         ef_reg    [0:LB][0:2];
    logic [LB-1:0]         ef_next   [0:LB][0:2];
    logic                  cap_reg   [0:LB][0:2];
    logic                  cap_next  [0:LB][0:2];
    logic [SW-1:0]         es_reg    [0:LB][0:2];
    logic [SW-1:0]         es_next   [0:LB][0:2];
    logic                  cpe_reg   [0:LB][0:2];
    logic                  cpe_next  [0:LB][0:2];
    logic [PWW-1:0]        col_reg   [0:2];
    logic [PWW-1:0]        col_next  [0:2];
    logic [PWW+15:0]       lp_reg    [0:2];
    logic [PWW+15:0]       lp_next   [0:2];
    logic [PWW-1:0]        cola_reg  [0:2];
    logic [PWW-1:0]        colb_reg  [0:2];
    logic [PWW-1:0]        luma_reg;
    logic [PWW-1:0]        luma_next;
    logic signed [PWW+16:0] pa_reg   [0:2];
    logic signed [PWW+16:0] pa_next  [0:2];
    logic signed [PWW+17:0] pb_reg;
    logic signed [PWW+17:0] pb_next;
    logic signed [VW-1:0]  v_reg     [0:2];
    logic signed [VW-1:0]  v_next    [0:2];
    logic signed [VW-1:0]  vx_reg    [0:2];
    logic [MXW-1:0]        mx_reg;
    logic [MXW-1:0]        mx_next;
    logic [NUMW-1:0]       rem_reg   [0:8][0:2];
    logic [NUMW-1:0]       rem_next  [0:8][0:2];
    logic [7:0]            q_reg     [0:8][0:2];
    logic [7:0]            q_next    [0:8][0:2];
    logic [MXW-1:0]        dmx_reg   [0:8];
    logic [MXW-1:0]        dmx_next  [0:8];
    logic [7:0]            alpha_reg [0:8];
    logic [7:0]            alpha_next[0:8];

    logic signed [BLW-1:0] bl_s;

    // Black level rescaled to the working fraction width, floored
    generate
        if (F >= 16) begin : g_bl_up
            assign bl_s = BLW'($signed(pedestal_reg)) <<< (F - 16);
        end else begin : g_bl_dn
            assign bl_s = BLW'($signed(pedestal_reg) >>> (16 - F));
        end
    endgenerate

    // Advance the whole pipeline when the output stage is free or taken
    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tlast  = lst_reg[NST-1];
    assign m_tdata  = {alpha_reg[8], q_reg[8][2], q_reg[8][1], q_reg[8][0]};

    assign vld_next = {vld_reg[NST-2:0], s_tvalid};
    assign lst_next = {lst_reg[NST-2:0], s_tlast};

    // Front: scale, levels, leading one, normalize, log2 squaring chain, gamma scaling
    always_comb begin
        logic [41:0]           rprod;
        logic signed [DW-1:0]  d;
        logic signed [DW+23:0] lprod;
        logic [CMW+29:0]       wide;
        logic [61:0]           sq;
        logic [31:0]           t;
        logic signed [LGW-1:0] lg;
        logic signed [LGW+16:0] gprod;
        for (int ch = 0; ch < 3; ch++) begin
            // byte * 2^F / 255
            rprod = 42'(s_tdata[8*ch +: 8]) * 42'(RECIP_255);
            n_next[ch] = NW'(rprod >> (RK - F));

            // subtract black level, scale by the reciprocal range
            d = $signed({2'b00, n_reg[ch]}) - DW'(bl_s);
            lprod = d * $signed(inv_range_reg);
            c_next[ch] = lprod[DW+23:16];

            // find the leading one of a positive level
            raw_next[ch] = c_reg[ch][CMW-1:0];
            cp0_next[ch] = !c_reg[ch][CW-1] && (c_reg[ch] != '0);
            p_next[ch] = '0;
            for (int j = 0; j < CMW; j++) begin
                if (c_reg[ch][j]) begin
                    p_next[ch] = PW'(j);
                end
            end

            // place the leading one at bit 30
            wide = {raw_reg[ch], 30'b0} >> p_reg[ch];
            lm_next[0][ch]  = wide[30:0];
            lf_next[0][ch]  = '0;
            lgi_next[0][ch] = LIW'(p_reg[ch]) - LIW'(F);
            cpl_next[0][ch] = cp0_reg[ch];

            // one log2 fraction bit per stage
            for (int j = 0; j < LB; j++) begin
                sq = 62'(lm_reg[j][ch]) * 62'(lm_reg[j][ch]);
                t  = sq[61:30];
                lm_next[j+1][ch]  = t[31] ? t[31:1] : t[30:0];
                lf_next[j+1][ch]  = {lf_reg[j][ch][LB-2:0], t[31]};
                lgi_next[j+1][ch] = lgi_reg[j][ch];
                cpl_next[j+1][ch] = cpl_reg[j][ch];
            end

            // scale the log by gamma
            lg = $signed({lgi_reg[LB][ch], lf_reg[LB][ch]});
            gprod = lg * $signed({1'b0, gamma_reg});
            y_next[ch]   = gprod[LGW+16:12];
            cpy_next[ch] = cpl_reg[LB][ch];
        end
    end

    // Back: exp2 product chain, power result, luma, mix, maximum, divide
    always_comb begin
        logic signed [KW-1:0]   k;
        logic [61:0]            eprod;
        logic [SW-1:0]          negs;
        logic [PWW+30:0]        lwide;
        logic [30:0]            rsh;
        logic [PWW-1:0]         pw;
        logic [PWW+17:0]        lsum;
        logic signed [16:0]     satc;
        logic signed [PWW+18:0] msum;
        logic signed [VW-1:0]   vv;
        logic signed [VW-1:0]   mxv;
        logic [MXW-1:0]         vc;
        logic [MXW+7:0]         am;
        logic [NUMW-1:0]        dv;
        lsum = '0;
        for (int ch = 0; ch < 3; ch++) begin
            // split into integer part and fraction, start exp2
            k = y_reg[ch][YW-1:LB];
            er_next[0][ch]  = 31'd1 << 30;
            ef_next[0][ch]  = y_reg[ch][LB-1:0];
            cap_next[0][ch] = (k >= K_CAP);
            es_next[0][ch]  = SW'(k) + SW'(F) - SW'(30);
            cpe_next[0][ch] = cpy_reg[ch];

            // multiply in one factor per fraction bit
            for (int j = 0; j < LB; j++) begin
                eprod = 62'(er_reg[j][ch]) * 62'(pcc_pkg::EXP_TAB[j]);
                er_next[j+1][ch]  = ef_reg[j][ch][LB-1-j] ? eprod[60:30] : er_reg[j][ch];
                ef_next[j+1][ch]  = ef_reg[j][ch];
                cap_next[j+1][ch] = cap_reg[j][ch];
                es_next[j+1][ch]  = es_reg[j][ch];
                cpe_next[j+1][ch] = cpe_reg[j][ch];
            end

            // shift the power to the working fraction width, saturate
            negs  = -es_reg[LB][ch];
            lwide = (PWW+31)'(er_reg[LB][ch]) << $unsigned(es_reg[LB][ch]);
            rsh   = er_reg[LB][ch] >> negs;
            if (cap_reg[LB][ch]) begin
                pw = POW_CAP;
            end else if (!es_reg[LB][ch][SW-1]) begin
                pw = lwide[PWW-1:0];
            end else if (negs >= SW'(31)) begin
                pw = '0;
            end else begin
                pw = PWW'(rsh);
            end
            if (!cpe_reg[LB][ch]) begin
                pw = (gamma_reg == '0) ? ONE_P : '0;
            end
            col_next[ch] = pw;

            // luma partial products
            lp_next[ch] = (PWW+16)'(pcc_pkg::LUMA_W[ch]) * (PWW+16)'(col_reg[ch]);
            lsum = lsum + (PWW+18)'(lp_reg[ch]);
        end
        luma_next = lsum[PWW+15:16];

        // mix toward luma
        satc = pcc_pkg::SAT_ONE - $signed({saturation_reg[15], saturation_reg});
        pb_next = satc * $signed({1'b0, luma_reg});
        for (int ch = 0; ch < 3; ch++) begin
            pa_next[ch] = $signed(saturation_reg) * $signed({1'b0, colb_reg[ch]});
            msum = pa_reg[ch] + pb_reg;
            vv = msum[PWW+18:12];
            v_next[ch] = (vv > FOUR_V) ? FOUR_V : vv;
        end

        // channel maximum with its floor
        mxv = VW'(MX_FLOOR);
        for (int ch = 0; ch < 3; ch++) begin
            if (v_reg[ch] > mxv) begin
                mxv = v_reg[ch];
            end
        end
        mx_next = mxv[MXW-1:0];

        // clip to [0, max], scale by 255, alpha
        am = {mx_reg, 8'b0} - (MXW+8)'(mx_reg);
        alpha_next[0] = am[F+9:F+2];
        dmx_next[0]   = mx_reg;
        for (int ch = 0; ch < 3; ch++) begin
            if (vx_reg[ch] < 0) begin
                vc = '0;
            end else if (vx_reg[ch] > $signed(VW'(mx_reg))) begin
                vc = mx_reg;
            end else begin
                vc = vx_reg[ch][MXW-1:0];
            end
            rem_next[0][ch] = {vc, 8'b0} - NUMW'(vc);
            q_next[0][ch]   = '0;
        end

        // one quotient bit per stage, most significant first
        for (int j = 0; j < 8; j++) begin
            alpha_next[j+1] = alpha_reg[j];
            dmx_next[j+1]   = dmx_reg[j];
            for (int ch = 0; ch < 3; ch++) begin
                dv = NUMW'(dmx_reg[j]) << (7 - j);
                if (rem_reg[j][ch] >= dv) begin
                    rem_next[j+1][ch] = rem_reg[j][ch] - dv;
                    q_next[j+1][ch]   = {q_reg[j][ch][6:0], 1'b1};
                end else begin
                    rem_next[j+1][ch] = rem_reg[j][ch];
                    q_next[j+1][ch]   = {q_reg[j][ch][6:0], 1'b0};
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pedestal_reg    <= pcc_pkg::PEDESTAL_RST;
            inv_range_reg   <= pcc_pkg::INV_RANGE_RST;
            gamma_reg       <= pcc_pkg::GAMMA_RST;
            saturation_reg  <= pcc_pkg::SATURATION_RST;
        end else if (cfg_wr_en) begin
            unique case (pcc_pkg::reg_idx_t'(cfg_addr))
                pcc_pkg::REG_PEDESTAL:    pedestal_reg    <= cfg_wdata[17:0];
                pcc_pkg::REG_INV_RANGE:   inv_range_reg   <= cfg_wdata;
                pcc_pkg::REG_GAMMA:       gamma_reg       <= cfg_wdata[15:0];
                pcc_pkg::REG_SATURATION:  saturation_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages, held on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            lst_reg  <= lst_next;
            luma_reg <= luma_next;
            pb_reg   <= pb_next;
            mx_reg   <= mx_next;
            for (int ch = 0; ch < 3; ch++) begin
                n_reg[ch]    <= n_next[ch];
                c_reg[ch]    <= c_next[ch];
                raw_reg[ch]  <= raw_next[ch];
                p_reg[ch]    <= p_next[ch];
                cp0_reg[ch]  <= cp0_next[ch];
                y_reg[ch]    <= y_next[ch];
                cpy_reg[ch]  <= cpy_next[ch];
                col_reg[ch]  <= col_next[ch];
                lp_reg[ch]   <= lp_next[ch];
                cola_reg[ch] <= col_reg[ch];
                colb_reg[ch] <= cola_reg[ch];
                pa_reg[ch]   <= pa_next[ch];
                v_reg[ch]    <= v_next[ch];
                vx_reg[ch]   <= v_reg[ch];
                for (int j = 0; j <= LB; j++) begin
                    lm_reg[j][ch]  <= lm_next[j][ch];
                    lf_reg[j][ch]  <= lf_next[j][ch];
                    lgi_reg[j][ch] <= lgi_next[j][ch];
                    cpl_reg[j][ch] <= cpl_next[j][ch];
                    er_reg[j][ch]  <= er_next[j][ch];
                    ef_reg[j][ch]  <= ef_next[j][ch];
                    cap_reg[j][ch] <= cap_next[j][ch];
                    es_reg[j][ch]  <= es_next[j][ch];
                    cpe_reg[j][ch] <= cpe_next[j][ch];
                end
                for (int j = 0; j <= 8; j++) begin
                    rem_reg[j][ch] <= rem_next[j][ch];
                    q_reg[j][ch]   <= q_next[j][ch];
                end
            end
            for (int j = 0; j <= 8; j++) begin
                dmx_reg[j]   <= dmx_next[j];
                alpha_reg[j] <= alpha_next[j];
            end
        end
    end

endmodule
